/* rtl/cbts_pkg.sv */
`timescale 1ns / 1ps

package cbts_pkg;

    // datapath widths
    localparam int DIV_W  = 29;
    localparam int CNT_W  = 5;
    localparam int BAUD_W = 20;
    localparam int SP_W   = 16;
    localparam int PROD_W = DIV_W + SP_W;

    // controller clock after reset
    localparam logic [DIV_W-1:0] CLOCK_HZ_RESET = 29'd42000000;

    // limits of a valid timing
    localparam logic [DIV_W-1:0] PRESC_MIN = 29'd2;
    localparam logic [DIV_W-1:0] PRESC_MAX = 29'd1024;
    // first part in quanta is sync quantum plus segment 1
    localparam logic [DIV_W-1:0] Q1_MIN    = 29'd2;
    localparam logic [DIV_W-1:0] Q1_MAX    = 29'd17;
    localparam logic [DIV_W-1:0] Q2_MIN    = 29'd1;
    localparam logic [DIV_W-1:0] Q2_MAX    = 29'd8;

    typedef enum logic [1:0] {
        ATT_NOM   = 2'd0,
        ATT_PLUS  = 2'd1,
        ATT_MINUS = 2'd2
    } t_attempt;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCLK_GO,
        S_DCLK_WAIT,
        S_MUL,
        S_TRY,
        S_GCD_GO,
        S_GCD_WAIT,
        S_CHK_P,
        S_DA_GO,
        S_DA_WAIT,
        S_DB_GO,
        S_DB_WAIT,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

/* rtl/cbts_divider.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module cbts_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cbts_pkg::DIV_W-1:0]   i_dividend,
    input  logic [cbts_pkg::DIV_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [cbts_pkg::DIV_W-1:0]   o_quotient
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [cbts_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [cbts_pkg::DIV_W-1:0]   r_quo, n_quo;
    logic [cbts_pkg::DIV_W-1:0]   r_rem, n_rem;
    logic [cbts_pkg::DIV_W-1:0]   r_dvs, n_dvs;
    logic                         r_zero, n_zero;
    logic [cbts_pkg::DIV_W:0]     w_rem_sh;
    logic [cbts_pkg::DIV_W:0]     w_diff;
    logic                         w_ge;

    assign w_rem_sh = {r_rem, r_quo[cbts_pkg::DIV_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_zero = (i_divisor == '0);
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[cbts_pkg::DIV_W-1:0] : w_rem_sh[cbts_pkg::DIV_W-1:0];
            n_quo = {r_quo[cbts_pkg::DIV_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == cbts_pkg::CNT_W'(cbts_pkg::DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_zero <= n_zero;
    end

    // division by zero reads as zero
    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : r_quo;

endmodule

/* rtl/cbts_gcd.sv */
`timescale 1ns / 1ps

// binary gcd, one shift or subtract step per cycle; both inputs nonzero
module cbts_gcd (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cbts_pkg::DIV_W-1:0]   i_a,
    input  logic [cbts_pkg::DIV_W-1:0]   i_b,
    output logic                         o_done,
    output logic [cbts_pkg::DIV_W-1:0]   o_gcd
);

    logic                         r_busy, n_busy;
    logic [cbts_pkg::DIV_W-1:0]   r_a, n_a;
    logic [cbts_pkg::DIV_W-1:0]   r_b, n_b;
    logic [cbts_pkg::CNT_W-1:0]   r_k, n_k;
    logic [cbts_pkg::DIV_W-1:0]   w_ab;
    logic [cbts_pkg::DIV_W-1:0]   w_ba;
    logic                         w_eq;

    assign w_ab = r_a - r_b;
    assign w_ba = r_b - r_a;
    assign w_eq = (r_a == r_b);

    always_comb begin
        n_busy = r_busy;
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_k    = '0;
        end else if (r_busy) begin
            if (w_eq) begin
                n_busy = 1'b0;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a > r_b) begin
                n_a = w_ab >> 1;
            end else begin
                n_b = w_ba >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
    end

    assign o_done = r_busy && w_eq;
    assign o_gcd  = r_a << r_k;

endmodule

/* rtl/can_bit_timing_solver_core.sv */
`timescale 1ns / 1ps

// channel      | dir | signals                        | contents (lowest bit up)
// config       | in  | i_cfg_wr_en, i_cfg_wr_data     | clock_hz[28:0]
// s_axis       | in  | tvalid, tready, tdata[39:0]    | baud_rate[19:0], sample_point_q16[35:20]
// m_axis       | out | tvalid, tready, tdata[23:0]    | ok, prescaler_code, seg1_code,
//              |     |                                | seg2_code, attempt_used
//
// one transfer at a time: a division gives the bit length, then each split attempt
// runs a binary gcd and, if the prescaler is in range, two divisions; a new item
// is taken only once the result of the last one has gone out
// s_axis_tready is high only while idle; the result is held until m_axis takes it
// synchronous active-low reset; clock_hz returns to 42 MHz
module can_bit_timing_solver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [28:0] i_cfg_wr_data,   // clock_hz
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,    // baud_rate[19:0], sample_point_q16[35:20], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // ok[0], prescaler_code[10:1], seg1_code[14:11],
                                         // seg2_code[17:15], attempt_used[19:18], zero pad
);

    cbts_pkg::t_state             r_state, n_state;
    cbts_pkg::t_attempt           r_att, n_att;

    logic [cbts_pkg::DIV_W-1:0]   r_clock_hz;
    logic [cbts_pkg::BAUD_W-1:0]  r_baud, n_baud;
    logic [cbts_pkg::SP_W-1:0]    r_sp, n_sp;
    logic [cbts_pkg::DIV_W-1:0]   r_bitclk, n_bitclk;
    logic [cbts_pkg::DIV_W-1:0]   r_base, n_base;
    logic [cbts_pkg::DIV_W-1:0]   r_split, n_split;
    logic [cbts_pkg::DIV_W-1:0]   r_rest, n_rest;
    logic [cbts_pkg::DIV_W-1:0]   r_pres, n_pres;
    logic [cbts_pkg::DIV_W-1:0]   r_q1, n_q1;

    // result register
    logic                         r_ok, n_ok;
    logic [9:0]                   r_pc, n_pc;
    logic [3:0]                   r_s1c, n_s1c;
    logic [2:0]                   r_s2c, n_s2c;
    logic [1:0]                   r_att_out, n_att_out;

    logic [cbts_pkg::PROD_W-1:0]  w_prod;
    logic [cbts_pkg::DIV_W-1:0]   w_split;
    logic                         w_split_bad;

    logic                         w_div_start;
    logic [cbts_pkg::DIV_W-1:0]   w_div_a;
    logic [cbts_pkg::DIV_W-1:0]   w_div_b;
    logic                         w_div_done;
    logic [cbts_pkg::DIV_W-1:0]   w_div_q;
    logic                         w_gcd_start;
    logic                         w_gcd_done;
    logic [cbts_pkg::DIV_W-1:0]   w_gcd;

    cbts_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    cbts_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_a     (r_split),
        .i_b     (r_rest),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    // nominal split = floor(bitclk * sample point / 65536)
    assign w_prod = r_bitclk * r_sp;

    // split for the current attempt; base never exceeds bitclk, so base+1 does not wrap
    always_comb begin
        w_split     = r_base;
        w_split_bad = 1'b0;
        unique case (r_att)
            cbts_pkg::ATT_NOM:   w_split = r_base;
            cbts_pkg::ATT_PLUS:  w_split = r_base + 1'b1;
            cbts_pkg::ATT_MINUS: begin
                w_split     = r_base - 1'b1;
                w_split_bad = (r_base == '0);
            end
            default: begin
                w_split     = r_base;
                w_split_bad = 1'b1;
            end
        endcase
        // empty first or second part
        if (w_split == '0 || w_split >= r_bitclk) begin
            w_split_bad = 1'b1;
        end
    end

    // divider operand select
    always_comb begin
        w_div_a = r_split;
        w_div_b = r_pres;
        priority case (r_state)
            cbts_pkg::S_DCLK_GO: begin
                w_div_a = r_clock_hz;
                w_div_b = {{(cbts_pkg::DIV_W - cbts_pkg::BAUD_W){1'b0}}, r_baud};
            end
            cbts_pkg::S_DB_GO: w_div_a = r_rest;
            default: w_div_a = r_split;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_att       = r_att;
        n_baud      = r_baud;
        n_sp        = r_sp;
        n_bitclk    = r_bitclk;
        n_base      = r_base;
        n_split     = r_split;
        n_rest      = r_rest;
        n_pres      = r_pres;
        n_q1        = r_q1;
        n_ok        = r_ok;
        n_pc        = r_pc;
        n_s1c       = r_s1c;
        n_s2c       = r_s2c;
        n_att_out   = r_att_out;
        w_div_start = 1'b0;
        w_gcd_start = 1'b0;

        unique case (r_state)
            cbts_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_baud  = s_axis_tdata[19:0];
                    n_sp    = s_axis_tdata[35:20];
                    n_state = cbts_pkg::S_DCLK_GO;
                end
            end
            cbts_pkg::S_DCLK_GO: begin
                w_div_start = 1'b1;
                n_state     = cbts_pkg::S_DCLK_WAIT;
            end
            cbts_pkg::S_DCLK_WAIT: begin
                if (w_div_done) begin
                    n_bitclk = w_div_q;
                    n_state  = cbts_pkg::S_MUL;
                end
            end
            cbts_pkg::S_MUL: begin
                n_base  = w_prod[cbts_pkg::PROD_W-1:cbts_pkg::SP_W];
                n_att   = cbts_pkg::ATT_NOM;
                n_state = cbts_pkg::S_TRY;
            end
            cbts_pkg::S_TRY: begin
                if (w_split_bad) begin
                    n_state = cbts_pkg::S_NEXT;
                end else begin
                    n_split = w_split;
                    n_rest  = r_bitclk - w_split;
                    n_state = cbts_pkg::S_GCD_GO;
                end
            end
            cbts_pkg::S_GCD_GO: begin
                w_gcd_start = 1'b1;
                n_state     = cbts_pkg::S_GCD_WAIT;
            end
            cbts_pkg::S_GCD_WAIT: begin
                if (w_gcd_done) begin
                    n_pres  = w_gcd;
                    n_state = cbts_pkg::S_CHK_P;
                end
            end
            cbts_pkg::S_CHK_P: begin
                if (r_pres < cbts_pkg::PRESC_MIN || r_pres > cbts_pkg::PRESC_MAX) begin
                    n_state = cbts_pkg::S_NEXT;
                end else begin
                    n_state = cbts_pkg::S_DA_GO;
                end
            end
            cbts_pkg::S_DA_GO: begin
                w_div_start = 1'b1;
                n_state     = cbts_pkg::S_DA_WAIT;
            end
            cbts_pkg::S_DA_WAIT: begin
                if (w_div_done) begin
                    n_q1    = w_div_q;
                    n_state = cbts_pkg::S_DB_GO;
                end
            end
            cbts_pkg::S_DB_GO: begin
                w_div_start = 1'b1;
                n_state     = cbts_pkg::S_DB_WAIT;
            end
            cbts_pkg::S_DB_WAIT: begin
                if (w_div_done) begin
                    if (r_q1 >= cbts_pkg::Q1_MIN && r_q1 <= cbts_pkg::Q1_MAX &&
                        w_div_q >= cbts_pkg::Q2_MIN && w_div_q <= cbts_pkg::Q2_MAX) begin
                        n_ok      = 1'b1;
                        n_pc      = 10'(r_pres - 1'b1);
                        n_s1c     = 4'(r_q1 - cbts_pkg::Q1_MIN);
                        n_s2c     = 3'(w_div_q - 1'b1);
                        n_att_out = r_att;
                        n_state   = cbts_pkg::S_OUT;
                    end else begin
                        n_state = cbts_pkg::S_NEXT;
                    end
                end
            end
            cbts_pkg::S_NEXT: begin
                priority case (r_att)
                    cbts_pkg::ATT_NOM: begin
                        n_att   = cbts_pkg::ATT_PLUS;
                        n_state = cbts_pkg::S_TRY;
                    end
                    cbts_pkg::ATT_PLUS: begin
                        n_att   = cbts_pkg::ATT_MINUS;
                        n_state = cbts_pkg::S_TRY;
                    end
                    default: begin
                        // no attempt fits: all fields zero
                        n_ok      = 1'b0;
                        n_pc      = '0;
                        n_s1c     = '0;
                        n_s2c     = '0;
                        n_att_out = '0;
                        n_state   = cbts_pkg::S_OUT;
                    end
                endcase
            end
            cbts_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    n_state = cbts_pkg::S_IDLE;
                end
            end
            default: n_state = cbts_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cbts_pkg::S_IDLE;
            r_clock_hz <= cbts_pkg::CLOCK_HZ_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_clock_hz <= i_cfg_wr_data;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_att     <= n_att;
        r_baud    <= n_baud;
        r_sp      <= n_sp;
        r_bitclk  <= n_bitclk;
        r_base    <= n_base;
        r_split   <= n_split;
        r_rest    <= n_rest;
        r_pres    <= n_pres;
        r_q1      <= n_q1;
        r_ok      <= n_ok;
        r_pc      <= n_pc;
        r_s1c     <= n_s1c;
        r_s2c     <= n_s2c;
        r_att_out <= n_att_out;
    end

    assign s_axis_tready = (r_state == cbts_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == cbts_pkg::S_OUT);
    assign m_axis_tdata  = {4'b0, r_att_out, r_s2c, r_s1c, r_pc, r_ok};

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // the slowest item inside the core fits well within this, so it covers any tail
    localparam int DRAIN_CYCLES = 600;

    // one solved bit timing as the core reports it
    typedef struct {
        bit                 ok;
        bit [9:0]           presc_code;
        bit [3:0]           seg1_code;
        bit [2:0]           seg2_code;
        cbts_pkg::t_attempt att;
    } t_timing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [28:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // baud_rate[19:0], sample_point_q16[35:20], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // ok, prescaler_code, seg1_code, seg2_code, attempt_used

    logic [39:0] pend_q[$];             // packed requests waiting for the driver
    t_timing     timing_q[$];           // predicted timings, oldest first
    bit [28:0]   clk_hz_model = cbts_pkg::CLOCK_HZ_RESET;
    bit          s_fire = 1'b0;
    int unsigned tx_gap_pct = 0;
    int unsigned rx_gap_pct = 0;
    int unsigned n_queued = 0;
    int unsigned n_checked = 0;
    int unsigned n_solved = 0;
    int unsigned n_att[3] = '{0, 0, 0};
    int unsigned n_cfg = 0;
    int unsigned err_cnt = 0;

    can_bit_timing_solver_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // one split of the bit: both parts must share a prescaler in range, and the
    // quanta count on each side must fit the segment limits (sync quantum included)
    function automatic t_timing try_split(longint unsigned bit_len, longint unsigned split);
        t_timing         r;
        longint unsigned rest, a, b, t, q1, q2;
        r.ok = 1'b0;
        r.presc_code = '0;
        r.seg1_code = '0;
        r.seg2_code = '0;
        r.att = cbts_pkg::ATT_NOM;
        if (split == 0 || split >= bit_len) return r;
        rest = bit_len - split;
        a = split;
        b = rest;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        if (a < cbts_pkg::PRESC_MIN || a > cbts_pkg::PRESC_MAX) return r;
        q1 = split / a;
        q2 = rest / a;
        if (q1 < cbts_pkg::Q1_MIN || q1 > cbts_pkg::Q1_MAX ||
            q2 < cbts_pkg::Q2_MIN || q2 > cbts_pkg::Q2_MAX) return r;
        r.ok = 1'b1;
        r.presc_code = 10'(a - 1);
        r.seg1_code = 4'(q1 - 2);
        r.seg2_code = 3'(q2 - 1);
        return r;
    endfunction

    // nominal split first, then base + 1, then base - 1 when base is nonzero
    function automatic t_timing solve_timing(bit [28:0] clk_hz, bit [19:0] baud, bit [15:0] sp);
        longint unsigned bit_len, base;
        t_timing         r;
        bit_len = (baud != 0) ? (longint'(clk_hz) / longint'(baud)) : 0;
        base = (bit_len * longint'(sp)) >> 16;
        r = try_split(bit_len, base);
        if (r.ok) return r;
        r = try_split(bit_len, base + 1);
        if (r.ok) begin
            r.att = cbts_pkg::ATT_PLUS;
            return r;
        end
        if (base != 0) begin
            r = try_split(bit_len, base - 1);
            if (r.ok) r.att = cbts_pkg::ATT_MINUS;
        end
        return r;
    endfunction

    task automatic report_field(input string fname, input int unsigned want,
                                input int unsigned got);
        err_cnt++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    endtask

    // request driver: a new request only once the previous one has been taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || s_fire) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
                s_axis_tdata <= pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_gap_pct);
    end

    // monitor: predict on request transfer, check on result transfer
    always @(posedge i_clk) begin : mon
        t_timing want;
        s_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            timing_q.push_back(solve_timing(clk_hz_model, s_axis_tdata[19:0],
                                            s_axis_tdata[35:20]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (timing_q.size() == 0) begin
                err_cnt++;
                $display("%0t ns: result with none expected, actual 0x%06h", $time,
                         m_axis_tdata);
            end else begin
                want = timing_q.pop_front();
                if (want.ok) begin
                    n_solved++;
                    n_att[want.att]++;
                end
                if (m_axis_tdata[0] != want.ok)
                    report_field("ok", want.ok, m_axis_tdata[0]);
                if (m_axis_tdata[10:1] != want.presc_code)
                    report_field("prescaler_code", want.presc_code, m_axis_tdata[10:1]);
                if (m_axis_tdata[14:11] != want.seg1_code)
                    report_field("seg1_code", want.seg1_code, m_axis_tdata[14:11]);
                if (m_axis_tdata[17:15] != want.seg2_code)
                    report_field("seg2_code", want.seg2_code, m_axis_tdata[17:15]);
                if (m_axis_tdata[19:18] != want.att)
                    report_field("attempt_used", want.att, m_axis_tdata[19:18]);
            end
        end
    end

    task automatic queue_item(input bit [19:0] baud, input bit [15:0] sp);
        pend_q.push_back({4'b0, sp, baud});
        n_queued++;
    endtask

    // a request built to land on or next to a valid timing for the current clock
    task automatic queue_solvable();
        int unsigned     nq, pres, blen, baud, q1, q1_lo, q1_hi, off;
        longint unsigned num, sp;
        nq = $urandom_range(3, 25);
        pres = $urandom_range(2, 1024);
        blen = pres * nq;
        baud = clk_hz_model / blen;
        if (baud == 0 || baud > 1000000) begin
            pres = 1024;
            blen = pres * nq;
            baud = clk_hz_model / blen;
        end
        if (baud == 0) baud = 1;
        if (baud > 1000000) baud = 1000000;
        // keep the second part within eight quanta
        q1_lo = (nq > 10) ? nq - 8 : 2;
        q1_hi = (nq - 1 < 17) ? nq - 1 : 17;
        q1 = $urandom_range(q1_lo, q1_hi);
        // aim the split at q1 * pres - 1, q1 * pres or q1 * pres + 1
        off = $urandom_range(0, 2);
        num = longint'(q1 * pres + off - 1) * 65536 + $urandom_range(0, 65535);
        sp = num / blen;
        if (sp > 65535) sp = 65535;
        queue_item(baud[19:0], sp[15:0]);
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 70) queue_solvable();
            else queue_item(20'($urandom), 16'($urandom));
        end
    endtask

    // quiet once every queued request has produced its checked result
    task automatic wait_idle(input int unsigned extra);
        do @(negedge i_clk); while (n_checked != n_queued);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_clock(input bit [28:0] hz);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= hz;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        clk_hz_model = hz;
        n_cfg++;
    endtask

    initial begin : stim
        bit [28:0]   clk_set[8];
        int unsigned phase_len[8];
        clk_set = '{29'd42000000, 29'd1000000, 29'd500000000, 29'h1FFFFFFF,
                    29'd0, 29'd80000000, 29'd16000000, 29'd0};
        clk_set[7] = 29'($urandom_range(1000000, 500000000));
        phase_len = '{130, 130, 120, 100, 20, 140, 130, 140};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_gap_pct = 12;
        rx_gap_pct = 61;

        // directed requests at the clock left by reset (42 MHz)
        queue_item(20'd0, 16'd0);              // zero bit rate
        queue_item(20'd0, 16'hFFFF);
        queue_item(20'hFFFFF, 16'hFFFF);       // both fields at their top
        queue_item(20'd1, 16'h8000);           // bit far too long for any prescaler
        queue_item(20'd1000000, 16'd52428);    // 80 percent, nominal split works
        queue_item(20'd500000, 16'd55784);     // nominal fails, the later split works
        queue_item(20'd500000, 16'd57344);     // only the earlier split works
        queue_item(20'd1000000, 16'd0);        // empty first part
        queue_item(20'd1000000, 16'hFFFF);     // sample point at its top, shortest second part
        queue_item(20'd250000, 16'd57344);
        queue_item(20'd125000, 16'hC000);
        queue_item(20'd100000, 16'hD999);
        queue_item(20'd83333, 16'hB333);
        queue_item(20'd1000000, 16'hC000);
        wait_idle(DRAIN_CYCLES);

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                tx_gap_pct = 12;
                rx_gap_pct = 61;
            end else if (p < 6) begin
                tx_gap_pct = 61;
                rx_gap_pct = 12;
            end else begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            write_clock(clk_set[p]);
            // zero rate, a rate above the clock at the slowest setting, slowest rate
            queue_item(20'd0, 16'($urandom));
            queue_item(20'hFFFFF, 16'd0);
            queue_item(20'd1, 16'($urandom));
            if (p == 1) begin
                // hold the sender back until the core has answered everything
                queue_random(phase_len[p] / 2);
                wait_idle(0);
                queue_random(phase_len[p] - phase_len[p] / 2);
            end else begin
                queue_random(phase_len[p]);
            end
            wait_idle(DRAIN_CYCLES);
        end

        if (timing_q.size() != 0) begin
            err_cnt++;
            $display("%0t ns: %0d expected results never arrived", $time, timing_q.size());
        end
        $display("checked %0d transfers over %0d clock settings", n_checked, n_cfg);
        $display("solved %0d (nominal %0d, later split %0d, earlier split %0d), unsolved %0d",
                 n_solved, n_att[0], n_att[1], n_att[2], n_checked - n_solved);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
